// File: design/sdsw_pkg.sv
// ----------------------------------------------------------------------------
// sdsw_pkg
// Shared types, constants and the segment encoder for the signed decimal
// segment writer.
// ----------------------------------------------------------------------------
package sdsw_pkg;

    localparam int VALUE_W        = 32;
    localparam int DISPLAY_DIGITS = 8;
    localparam int ADDR_W         = 4;
    localparam int SEG_W          = 8;
    localparam int NIBBLE_W       = 4;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = BCD_DIGITS * NIBBLE_W;
    localparam int DD_STAGES      = 4;
    localparam int DD_BITS        = VALUE_W / DD_STAGES;
    localparam int FRAME_W        = DISPLAY_DIGITS * NIBBLE_W;

    localparam logic [SEG_W-1:0] SEG_ZERO  = 8'h7E;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;

    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_MINUS,
        PH_DIGIT
    } phase_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [NIBBLE_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h7E;
            4'd1:    s = 8'h30;
            4'd2:    s = 8'h6D;
            4'd3:    s = 8'h79;
            4'd4:    s = 8'h33;
            4'd5:    s = 8'h5B;
            4'd6:    s = 8'h5F;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h7B;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: design/sdsw_sign.sv
// ----------------------------------------------------------------------------
// sdsw_sign
// First pipeline stage: split the input word into sign and unsigned magnitude
// and seed the BCD conversion.
// ----------------------------------------------------------------------------
module sdsw_sign
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sdsw_pkg::VALUE_W-1:0]  in_value,
    output logic                          in_ready,
    output logic                          out_valid,
    output sdsw_pkg::dd_t                 out_data,
    input  logic                          out_ready
);
    import sdsw_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.neg = in_value[VALUE_W-1];
        data_next.bcd = '0;
        data_next.bin = in_value[VALUE_W-1] ? (~in_value + {{(VALUE_W-1){1'b0}}, 1'b1})
                                            : in_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/sdsw_dabble.sv
// ----------------------------------------------------------------------------
// sdsw_dabble
// One shift-and-add-3 stage: converts the next DD_BITS magnitude bits into
// the running BCD value.
// ----------------------------------------------------------------------------
module sdsw_dabble
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sdsw_pkg::dd_t in_data,
    output logic          in_ready,
    output logic          out_valid,
    output sdsw_pkg::dd_t out_data,
    input  logic          out_ready
);
    import sdsw_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        bcd = in_data.bcd;
        bin = in_data.bin;
        for (int s = 0; s < DD_BITS; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (bcd[d*NIBBLE_W +: NIBBLE_W] >= 4'd5)
                begin
                    bcd[d*NIBBLE_W +: NIBBLE_W] = bcd[d*NIBBLE_W +: NIBBLE_W] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
            bin = {bin[VALUE_W-2:0], 1'b0};
        end
        data_next.neg = in_data.neg;
        data_next.bcd = bcd;
        data_next.bin = bin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/sdsw_emit.sv
// ----------------------------------------------------------------------------
// sdsw_emit
// Write sequencer: clears all digits, then writes any minus sign and the
// decimal digits via an output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module sdsw_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  sdsw_pkg::dd_t                 in_data,
    output logic                          in_ready,
    output logic                          write_valid,
    input  logic                          write_stall,
    output logic [sdsw_pkg::ADDR_W-1:0]   digit_address,
    output logic [sdsw_pkg::SEG_W-1:0]    segments,
    output logic                          last_write
);
    import sdsw_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    logic [ADDR_W-1:0]   ndig_reg;
    logic                minus_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [FRAME_W-1:0]  frame_next;

    logic                ovalid_reg;
    logic [ADDR_W-1:0]   oaddr_reg;
    logic [SEG_W-1:0]    oseg_reg;
    logic                olast_reg;

    logic                slot_free;
    logic                advance;
    logic                load;
    logic [ADDR_W-1:0]   w_addr;
    logic [SEG_W-1:0]    w_seg;
    logic                w_last;

    logic [ADDR_W-1:0]   digits;
    logic [ADDR_W-1:0]   ndig_in;
    logic                minus_in;

    assign slot_free = !ovalid_reg || !write_stall;
    assign advance   = (phase_reg != PH_IDLE) && slot_free;
    assign in_ready  = (phase_reg == PH_IDLE) || (advance && w_last);
    assign load      = in_ready && in_valid;

    always_comb
    begin
        digits = '0;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (in_data.bcd[d*NIBBLE_W +: NIBBLE_W] != '0)
            begin
                digits = ADDR_W'(d + 1);
            end
        end
        ndig_in  = (digits > ADDR_W'(DISPLAY_DIGITS)) ? ADDR_W'(DISPLAY_DIGITS) : digits;
        minus_in = in_data.neg && (digits != '0) && (digits < ADDR_W'(DISPLAY_DIGITS));
    end

    always_comb
    begin
        w_addr = addr_reg;
        w_seg  = SEG_ZERO;
        w_last = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                w_addr = addr_reg;
            end
            PH_CLEAR:
            begin
                w_last = (addr_reg == ADDR_W'(1)) && (ndig_reg == '0);
            end
            PH_MINUS:
            begin
                w_addr = ndig_reg + ADDR_W'(1);
                w_seg  = SEG_MINUS;
            end
            PH_DIGIT:
            begin
                w_seg  = seg_of(frame_reg[NIBBLE_W-1:0]);
                w_last = (addr_reg == ndig_reg);
            end
            default:
            begin
                w_addr = addr_reg;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        frame_next = frame_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_CLEAR:
                begin
                    addr_next = addr_reg - ADDR_W'(1);
                    if (addr_reg == ADDR_W'(1))
                    begin
                        addr_next = ADDR_W'(1);
                        if (minus_reg)
                        begin
                            phase_next = PH_MINUS;
                        end
                        else if (ndig_reg != '0)
                        begin
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_MINUS:
                begin
                    phase_next = PH_DIGIT;
                end
                PH_DIGIT:
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    frame_next = {{NIBBLE_W{1'b0}}, frame_reg[FRAME_W-1:NIBBLE_W]};
                    if (w_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        if (load)
        begin
            phase_next = PH_CLEAR;
            addr_next  = ADDR_W'(DISPLAY_DIGITS);
            frame_next = in_data.bcd[FRAME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (slot_free)
            begin
                ovalid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        frame_reg <= frame_next;
        if (load)
        begin
            ndig_reg  <= ndig_in;
            minus_reg <= minus_in;
        end
        if (advance)
        begin
            oaddr_reg <= w_addr;
            oseg_reg  <= w_seg;
            olast_reg <= w_last;
        end
    end

    assign write_valid   = ovalid_reg;
    assign digit_address = oaddr_reg;
    assign segments      = oseg_reg;
    assign last_write    = olast_reg;

endmodule

// File: design/signed_decimal_segment_writer_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_segment_writer_core
// Turns a signed 32-bit word into the run of digit-register writes that show
// it in decimal on an 8-digit seven-segment panel.
//
//   channel  direction  handshake                   payload
//   value    in         value_valid / value_stall   value[31:0]
//   write    out        write_valid / write_stall   digit_address, segments, last_write
//
// A word passes a sign stage and four shift-and-add-3 stages, then the write
// sequencer, which issues one write per cycle while write_stall is low, 8 to
// 16 writes per word (eight clears, then any minus sign and the digits). The
// conversion pipeline keeps up to five words in flight behind it. Reset clears
// all valid bits and returns the sequencer to idle. A stall on the write side
// holds the output register and backs up the pipeline stage by stage.
// ----------------------------------------------------------------------------
module signed_decimal_segment_writer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [sdsw_pkg::VALUE_W-1:0]  value,
    output logic                          write_valid,
    input  logic                          write_stall,
    output logic [sdsw_pkg::ADDR_W-1:0]   digit_address,
    output logic [sdsw_pkg::SEG_W-1:0]    segments,
    output logic                          last_write
);
    import sdsw_pkg::*;

    logic sign_ready;
    logic stg_valid [DD_STAGES+1];
    logic stg_ready [DD_STAGES+1];
    dd_t  stg_data  [DD_STAGES+1];

    assign value_stall = !sign_ready;

    sdsw_sign u_sign
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (value_valid),
        .in_value  (value),
        .in_ready  (sign_ready),
        .out_valid (stg_valid[0]),
        .out_data  (stg_data[0]),
        .out_ready (stg_ready[0])
    );

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dabble
        sdsw_dabble u_dabble
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_data   (stg_data[g]),
            .in_ready  (stg_ready[g]),
            .out_valid (stg_valid[g+1]),
            .out_data  (stg_data[g+1]),
            .out_ready (stg_ready[g+1])
        );
    end

    sdsw_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stg_valid[DD_STAGES]),
        .in_data       (stg_data[DD_STAGES]),
        .in_ready      (stg_ready[DD_STAGES]),
        .write_valid   (write_valid),
        .write_stall   (write_stall),
        .digit_address (digit_address),
        .segments      (segments),
        .last_write    (last_write)
    );

endmodule
